// ===== rtl/core/ipv4rx_pkg.sv =====
// Package for the IPv4 receive header check: sizes, protocol numbers,
// verdict codes and the frame snapshot type passed between the stages.
// No dependencies.
package ipv4rx_pkg;

  // Frame limits.
  localparam int unsigned MAX_FRAME_BYTES   = 2048;
  localparam int unsigned LINK_HEADER_BYTES = 14;
  localparam int unsigned IP_MIN_HEADER     = 20;

  // Widths.
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // Header constants.
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
  localparam logic [31:0] BCAST_ADDRESS = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_CONFIGURED = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS   = 1'b1;

  // Verdict codes.
  typedef enum logic [3:0] {
    ST_UDP        = 4'd0,
    ST_TCP        = 4'd1,
    ST_OTHER      = 4'd2,
    ST_SHORT      = 4'd3,
    ST_VERSION    = 4'd4,
    ST_HDR_LEN    = 4'd5,
    ST_TOTAL_LEN  = 4'd6,
    ST_CHECKSUM   = 4'd7,
    ST_FRAGMENT   = 4'd8,
    ST_NOT_OURS   = 4'd9,
    ST_TOO_LONG   = 4'd10
  } status_t;

  // Everything captured from one frame, taken on its last byte.
  typedef struct packed {
    logic [COUNT_W-1:0] size;
    logic [7:0]         ver_len;
    logic [15:0]        total_len;
    logic [15:0]        frag;
    logic [7:0]         proto;
    logic [31:0]        src;
    logic [31:0]        dst;
    logic [15:0]        sum;
  } frame_snap_t;

endpackage

// ===== rtl/core/ipv4rx_in_if.sv =====
// Byte stream channel carrying the received frame into the header check.
// No dependencies.
interface ipv4rx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// ===== rtl/core/ipv4rx_out_if.sv =====
// Verdict channel carrying one result per frame out of the header check.
// No dependencies.
interface ipv4rx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [5:0]  header_bytes;
  logic [15:0] payload_length;

  modport source(output valid, status, protocol, source_address, destination_address,
                 header_bytes, payload_length, input ready);
  modport sink(input valid, status, protocol, source_address, destination_address,
               header_bytes, payload_length, output ready);
endinterface

// ===== rtl/core/ipv4rx_capture.sv =====
// Per-frame capture stage: byte counter, header field capture and the running
// one's-complement checksum. Depends on ipv4rx_pkg and ipv4rx_in_if.
module ipv4rx_capture
  import ipv4rx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ipv4rx_in_if.sink    in_ch,
  input  logic         snap_take,
  output logic         snap_valid,
  output frame_snap_t  snap
);

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]         ver_len_r, ver_len_nxt;
  logic [15:0]        total_len_r, total_len_nxt;
  logic [15:0]        frag_r, frag_nxt;
  logic [7:0]         proto_r, proto_nxt;
  logic [31:0]        src_r, src_nxt;
  logic [31:0]        dst_r, dst_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic [7:0]         hold_r, hold_nxt;

  logic               snap_valid_r, snap_valid_nxt;
  frame_snap_t        snap_r, snap_nxt;

  logic               in_acc;
  logic               snap_ready;
  logic               in_hdr;
  logic [COUNT_W-1:0] off;
  logic [3:0]         ihl;
  logic [5:0]         hs;
  logic [16:0]        sum_wide;
  logic [7:0]         b;

  assign snap_ready  = !snap_valid_r || snap_take;
  assign in_ch.ready = snap_ready;
  assign in_acc      = in_ch.valid && snap_ready;
  assign b           = in_ch.data_byte;

  assign in_hdr = byte_count_r >= COUNT_W'(LINK_HEADER_BYTES);
  assign off    = byte_count_r - COUNT_W'(LINK_HEADER_BYTES);

  // The header length in force includes a version byte arriving right now.
  assign ihl      = (off == '0) ? b[3:0] : ver_len_r[3:0];
  assign hs       = {ihl, 2'b00};
  assign sum_wide = {1'b0, sum_r} + {1'b0, hold_r, b};

  // Field capture, checksum and frame bookkeeping.
  always_comb begin
    byte_count_nxt = byte_count_r;
    ver_len_nxt    = ver_len_r;
    total_len_nxt  = total_len_r;
    frag_nxt       = frag_r;
    proto_nxt      = proto_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    sum_nxt        = sum_r;
    hold_nxt       = hold_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_valid_r;

    if (in_acc) begin
      if (in_hdr) begin
        if (off == COUNT_W'(0)) ver_len_nxt = b;
        if (off == COUNT_W'(2)) total_len_nxt[15:8] = b;
        if (off == COUNT_W'(3)) total_len_nxt[7:0] = b;
        if (off == COUNT_W'(6)) frag_nxt[15:8] = b;
        if (off == COUNT_W'(7)) frag_nxt[7:0] = b;
        if (off == COUNT_W'(9)) proto_nxt = b;
        if (off[COUNT_W-1:2] == (COUNT_W-2)'(3)) src_nxt = {src_r[23:0], b};
        if (off[COUNT_W-1:2] == (COUNT_W-2)'(4)) dst_nxt = {dst_r[23:0], b};

        // Sum 16-bit words over the first IHL*4 header bytes.
        if (off[COUNT_W-1:6] == '0 && off[5:0] < hs) begin
          if (!off[0]) begin
            hold_nxt = b;
          end else if (sum_wide[16]) begin
            sum_nxt = sum_wide[15:0] + 16'd1;
          end else begin
            sum_nxt = sum_wide[15:0];
          end
        end
      end

      if (byte_count_r != '1) byte_count_nxt = byte_count_r + COUNT_W'(1);

      // On the last byte, hand the frame to the verdict stage and start over.
      if (in_ch.last_byte) begin
        snap_nxt.size      = byte_count_nxt;
        snap_nxt.ver_len   = ver_len_nxt;
        snap_nxt.total_len = total_len_nxt;
        snap_nxt.frag      = frag_nxt;
        snap_nxt.proto     = proto_nxt;
        snap_nxt.src       = src_nxt;
        snap_nxt.dst       = dst_nxt;
        snap_nxt.sum       = sum_nxt;
        byte_count_nxt = '0;
        ver_len_nxt    = '0;
        total_len_nxt  = '0;
        frag_nxt       = '0;
        proto_nxt      = '0;
        src_nxt        = '0;
        dst_nxt        = '0;
        sum_nxt        = '0;
        hold_nxt       = '0;
      end
    end

    if (snap_ready) snap_valid_nxt = in_acc && in_ch.last_byte;
  end

  // Frame state and snapshot valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ver_len_r    <= '0;
      total_len_r  <= '0;
      frag_r       <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      sum_r        <= '0;
      hold_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      ver_len_r    <= ver_len_nxt;
      total_len_r  <= total_len_nxt;
      frag_r       <= frag_nxt;
      proto_r      <= proto_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      sum_r        <= sum_nxt;
      hold_r       <= hold_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  // Snapshot payload needs no reset.
  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== rtl/core/ipv4rx_verdict.sv =====
// Verdict stage: runs the header checks on a frame snapshot and holds the
// result in the output register. Depends on ipv4rx_pkg and ipv4rx_out_if.
module ipv4rx_verdict
  import ipv4rx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         snap_valid,
  input  frame_snap_t  snap,
  output logic         snap_take,
  input  logic         addr_configured,
  input  logic [31:0]  local_address,
  ipv4rx_out_if.source out_ch
);

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [5:0]  hs_r;
  logic [15:0] payload_r, payload_nxt;

  logic [5:0]         hs;
  logic [COUNT_W-1:0] avail;
  logic               load;

  assign snap_take = !out_valid_r || out_ch.ready;
  assign load      = snap_valid && snap_take;

  assign hs    = {snap.ver_len[3:0], 2'b00};
  assign avail = (snap.size >= COUNT_W'(LINK_HEADER_BYTES)) ?
                 snap.size - COUNT_W'(LINK_HEADER_BYTES) : '0;

  // Checks in priority order, then the protocol class.
  always_comb begin
    payload_nxt = '0;
    if (snap.size > COUNT_W'(MAX_FRAME_BYTES)) begin
      status_nxt = ST_TOO_LONG;
    end else if (snap.size < COUNT_W'(LINK_HEADER_BYTES + IP_MIN_HEADER)) begin
      status_nxt = ST_SHORT;
    end else if (snap.ver_len[7:4] != IP_VERSION4) begin
      status_nxt = ST_VERSION;
    end else if (hs < 6'(IP_MIN_HEADER) || COUNT_W'(hs) > avail) begin
      status_nxt = ST_HDR_LEN;
    end else if (snap.total_len < 16'(hs) || snap.total_len > avail) begin
      status_nxt = ST_TOTAL_LEN;
    end else if (snap.sum != SUM_GOOD) begin
      status_nxt = ST_CHECKSUM;
    end else if ((snap.frag & FRAG_MASK) != '0) begin
      status_nxt = ST_FRAGMENT;
    end else if (addr_configured && snap.dst != local_address &&
                 snap.dst != BCAST_ADDRESS) begin
      status_nxt = ST_NOT_OURS;
    end else begin
      if (snap.proto == PROTO_UDP) begin
        status_nxt = ST_UDP;
      end else if (snap.proto == PROTO_TCP) begin
        status_nxt = ST_TCP;
      end else begin
        status_nxt = ST_OTHER;
      end
      payload_nxt = snap.total_len - 16'(hs);
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (snap_take) out_valid_nxt = snap_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded as the snapshot moves over.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r  <= status_nxt;
      proto_r   <= snap.proto;
      src_r     <= snap.src;
      dst_r     <= snap.dst;
      hs_r      <= hs;
      payload_r <= payload_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = status_r;
  assign out_ch.protocol            = proto_r;
  assign out_ch.source_address      = src_r;
  assign out_ch.destination_address = dst_r;
  assign out_ch.header_bytes        = hs_r;
  assign out_ch.payload_length      = payload_r;

`ifndef NO_ASSERTIONS
  // A rejected frame never reports a payload length.
  a_reject_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_UDP && status_r != ST_TCP && status_r != ST_OTHER)
    |-> payload_r == '0)
    else $error("rejected frame carries a payload length");

  // Header length is always a whole number of 32-bit words.
  a_hs_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> hs_r[1:0] == 2'b00)
    else $error("header length not a multiple of four");

  // A waiting snapshot is kept while the output register is stalled.
  a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_valid && !snap_take) |=> snap_valid && $stable(snap))
    else $error("snapshot lost while output stalled");

  // An accepted frame reaches the output register on the next edge.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded verdict not presented");
`endif

endmodule

// ===== rtl/core/ipv4_receive_header_check.sv =====
// Top level of the IPv4 receive header check: configuration registers and
// the capture and verdict stages. Depends on ipv4rx_pkg, ipv4rx_in_if,
// ipv4rx_out_if, ipv4rx_capture and ipv4rx_verdict.
//
// Usage:
// The in_ch channel takes one byte of a received Ethernet frame per request,
// with last_byte marking the final byte. The link header is skipped and the
// IPv4 header fields are captured while the one's-complement checksum is
// summed. A frame streams at one byte per clock with no gap between frames,
// except while a waiting snapshot holds in_ch ready low.
// Each frame yields one request on out_ch: a status code, the captured
// protocol, addresses, header length and payload length. The snapshot
// register takes the frame on its last byte, and the output register then
// takes the verdict from it.
// When out_ch stalls, the output register holds its result and the next
// frame waits in the snapshot register; while that frame waits, in_ch
// ready is low and no byte is taken.
// The cfg port writes address_configured (index 0) and local_address
// (index 1); the user must write them only while no frame is in flight,
// as the block itself does not enforce it. Reset clears the capture state,
// both registers and both valid flags; the block is ready the cycle after.
module ipv4_receive_header_check
  import ipv4rx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  ipv4rx_in_if.sink              in_ch,
  ipv4rx_out_if.source           out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic        addr_configured_r, addr_configured_nxt;
  logic [31:0] local_address_r, local_address_nxt;

  logic        snap_valid;
  logic        snap_take;
  frame_snap_t snap;

  // Configuration register writes.
  always_comb begin
    addr_configured_nxt = addr_configured_r;
    local_address_nxt   = local_address_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ADDR_CONFIGURED: addr_configured_nxt = cfg_wdata[0];
        CFG_LOCAL_ADDRESS:   local_address_nxt   = cfg_wdata[31:0];
        default: begin
          addr_configured_nxt = addr_configured_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_configured_r <= 1'b0;
      local_address_r   <= '0;
    end else begin
      addr_configured_r <= addr_configured_nxt;
      local_address_r   <= local_address_nxt;
    end
  end

  // Frame capture and snapshot.
  ipv4rx_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Checks and output register.
  ipv4rx_verdict u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_valid      (snap_valid),
    .snap            (snap),
    .snap_take       (snap_take),
    .addr_configured (addr_configured_r),
    .local_address   (local_address_r),
    .out_ch          (out_ch)
  );

endmodule
